### sv/vrot_pkg.sv
// ----------------------------------------------------------------------------
// vrot_pkg
// Shared types, defaults and the quarter-wave sine generator used to build the
// coefficient ROM of the three-axis vector rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package vrot_pkg;

	// default table resolution and coefficient precision
	localparam int ANGLE_INDEX_BITS = 12;
	localparam int COEF_FRAC_BITS   = 15;

	// 2*pi in Q4.60
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam longint      ONE_Q30    = 64'sh0000_0000_4000_0000;

	// rotation axis of one step, names the component pair (a, b)
	typedef enum logic [1:0] {
		AXIS_X, // (y, z)
		AXIS_Y, // (z, x)
		AXIS_Z  // (x, y)
	} axis_t;

	// vector plus running saturation flag
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               clip;
	} vec_t;

	// sin of j table steps (0..quarter turn), Q2.30, 8-term taylor series
	function automatic longint sin_quarter_q30(input longint unsigned j, input int bits);
		longint unsigned theta;
		longint unsigned theta2;
		longint unsigned term;
		longint          sum;
		theta  = ((TWO_PI_Q60 >> bits) * j) >> 30;
		theta2 = (theta * theta) >> 30;
		term   = theta;
		sum    = longint'(theta);
		term   = ((term * theta2) >> 30) / 6;
		sum    = sum - longint'(term);
		term   = ((term * theta2) >> 30) / 20;
		sum    = sum + longint'(term);
		term   = ((term * theta2) >> 30) / 42;
		sum    = sum - longint'(term);
		term   = ((term * theta2) >> 30) / 72;
		sum    = sum + longint'(term);
		term   = ((term * theta2) >> 30) / 110;
		sum    = sum - longint'(term);
		term   = ((term * theta2) >> 30) / 156;
		sum    = sum + longint'(term);
		term   = ((term * theta2) >> 30) / 210;
		sum    = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		if (sum > ONE_Q30)
			sum = ONE_Q30;
		return sum;
	endfunction

	// quarter-wave magnitude rounded half up to frac fractional bits
	function automatic longint quarter_coef(input longint unsigned j, input int bits,
			input int frac);
		longint s;
		s = sin_quarter_q30(j, bits);
		s = (s + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
		return s;
	endfunction

endpackage

`default_nettype wire

### sv/vector_rotate_xyz_int16.sv
// ----------------------------------------------------------------------------
// vector_rotate_xyz_int16
// Euler-angle rotation of a signed 16-bit vector by three binary angles,
// forward X-Y-Z or inverse Z-Y-X with negated angles, saturating per step.
// ----------------------------------------------------------------------------
// Pipeline: two stages of table lookup, then two stages per axis step
//   (multiply, combine/saturate) between input transfer and output valid.
// Throughput: one vector per cycle unless the output stalls; each stage
//   loads when it is empty or when its successor advances.
// Reset: clears only the stage valid bits; coefficient ROM is constant.
`default_nettype none

module vector_rotate_xyz_int16 #(
	parameter int ANGLE_INDEX_BITS = vrot_pkg::ANGLE_INDEX_BITS,
	parameter int COEF_FRAC_BITS   = vrot_pkg::COEF_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // vec_x, vec_y, vec_z, angle_x, angle_y, angle_z
	input  wire logic        s_axis_tuser,  // op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata,  // out_x, out_y, out_z
	output logic             m_axis_tuser   // clipped
);

	localparam int NSTG = 8;
	localparam int F    = COEF_FRAC_BITS;

	typedef struct packed {
		logic        op;
		logic [15:0] ang1;
		logic [15:0] ang2;
	} side_t;

	logic [NSTG+1:1] adv;
	logic [NSTG:1]   vld_q;
	logic [NSTG:1]   vld_in;

	logic [15:0]     ang_x;
	logic [15:0]     ang_y;
	logic [15:0]     ang_z;
	logic [15:0]     ang0;
	side_t           side_in;
	vrot_pkg::vec_t  vec_in;

	side_t           side_s [1:6];
	vrot_pkg::vec_t  vec_s1;
	vrot_pkg::vec_t  vec_s2;

	logic [15:0]     ang    [3];
	vrot_pkg::axis_t axis   [3];
	vrot_pkg::vec_t  vsrc   [3];
	vrot_pkg::vec_t  vout   [3];
	logic [F:0]      sin_mag [3];
	logic [F:0]      cos_mag [3];
	logic            sin_neg [3];
	logic            cos_neg [3];

	// per-stage advance: a stage loads when it is empty or its successor moves
	always_comb begin
		adv[NSTG+1] = m_axis_tready;
		for (int i = NSTG; i >= 1; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign s_axis_tready = adv[1];
	assign vld_in        = {vld_q[NSTG-1:1], s_axis_tvalid};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NSTG; i++)
				if (adv[i])
					vld_q[i] <= vld_in[i];
		end
	end

	// step angles in execution order, inverse negates with 16-bit wrap
	always_comb begin
		ang_x        = s_axis_tdata[63:48];
		ang_y        = s_axis_tdata[79:64];
		ang_z        = s_axis_tdata[95:80];
		ang0         = s_axis_tuser ? 16'(-ang_z) : ang_x;
		side_in.op   = s_axis_tuser;
		side_in.ang1 = s_axis_tuser ? 16'(-ang_y) : ang_y;
		side_in.ang2 = s_axis_tuser ? 16'(-ang_x) : ang_z;
		vec_in.x     = s_axis_tdata[15:0];
		vec_in.y     = s_axis_tdata[31:16];
		vec_in.z     = s_axis_tdata[47:32];
		vec_in.clip  = 1'b0;
	end

	// sideband and vector carried alongside the lookup stages
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			side_s[1] <= side_in;
			vec_s1    <= vec_in;
		end
		if (adv[2])
			vec_s2 <= vec_s1;
		for (int i = 2; i <= 6; i++)
			if (adv[i])
				side_s[i] <= side_s[i-1];
	end

	// step wiring: lookup runs two stages ahead of each rotation
	always_comb begin
		ang[0]  = ang0;
		ang[1]  = side_s[2].ang1;
		ang[2]  = side_s[4].ang2;
		axis[0] = side_s[2].op ? vrot_pkg::AXIS_Z : vrot_pkg::AXIS_X;
		axis[1] = vrot_pkg::AXIS_Y;
		axis[2] = side_s[6].op ? vrot_pkg::AXIS_X : vrot_pkg::AXIS_Z;
		vsrc[0] = vec_s2;
		vsrc[1] = vout[0];
		vsrc[2] = vout[1];
	end

	for (genvar k = 0; k < 3; k++) begin : g_step
		vrot_coef #(
			.ANGLE_INDEX_BITS(ANGLE_INDEX_BITS),
			.COEF_FRAC_BITS  (COEF_FRAC_BITS)
		) u_coef (
			.clk    (clk),
			.en_a   (adv[2*k+1]),
			.en_b   (adv[2*k+2]),
			.angle  (ang[k]),
			.sin_mag(sin_mag[k]),
			.sin_neg(sin_neg[k]),
			.cos_mag(cos_mag[k]),
			.cos_neg(cos_neg[k])
		);

		vrot_step #(
			.COEF_FRAC_BITS(COEF_FRAC_BITS)
		) u_step (
			.clk    (clk),
			.en_a   (adv[2*k+3]),
			.en_b   (adv[2*k+4]),
			.vin    (vsrc[k]),
			.axis   (axis[k]),
			.sin_mag(sin_mag[k]),
			.sin_neg(sin_neg[k]),
			.cos_mag(cos_mag[k]),
			.cos_neg(cos_neg[k]),
			.vout   (vout[k])
		);
	end

	// result transfer
	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = {vout[2].z, vout[2].y, vout[2].x};
	assign m_axis_tuser  = vout[2].clip;

	// input is refused only when every stage is full and the output stalls
	a_ready_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!(&vld_q) || m_axis_tready))
		else $error("input ready disagrees with pipeline occupancy");

	// first stage only fills from an input transfer
	a_fill_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_q[1]) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("first stage filled without an input transfer");

	// a held mid-pipeline item is not dropped
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] && !adv[5] |=> vld_q[4])
		else $error("stalled item lost in the pipeline");

endmodule

`default_nettype wire

### sv/vrot_coef.sv
// ----------------------------------------------------------------------------
// vrot_coef
// Angle to sine/cosine lookup: quadrant folding in the first stage, a
// two-port quarter-wave ROM with registered output in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module vrot_coef #(
	parameter int ANGLE_INDEX_BITS = vrot_pkg::ANGLE_INDEX_BITS,
	parameter int COEF_FRAC_BITS   = vrot_pkg::COEF_FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      en_a,
	input  wire logic                      en_b,
	input  wire logic [15:0]               angle,
	output logic      [COEF_FRAC_BITS:0]   sin_mag,
	output logic                           sin_neg,
	output logic      [COEF_FRAC_BITS:0]   cos_mag,
	output logic                           cos_neg
);

	localparam int B   = ANGLE_INDEX_BITS;
	localparam int F   = COEF_FRAC_BITS;
	localparam int QTR = 1 << (B - 2);
	localparam int JW  = B - 1;

	typedef logic [F:0] rom_t [QTR+1];

	function automatic rom_t build_rom();
		rom_t rom;
		for (int j = 0; j <= QTR; j++)
			rom[j] = (F+1)'(vrot_pkg::quarter_coef(longint'(j), B, F));
		return rom;
	endfunction

	localparam rom_t SIN_ROM = build_rom();

	logic [B-1:0]  idx;
	logic [1:0]    q_sin;
	logic [1:0]    q_cos;
	logic [JW-1:0] r_ext;
	logic [JW-1:0] j_sin;
	logic [JW-1:0] j_cos;

	logic [JW-1:0] j_sin_s1;
	logic [JW-1:0] j_cos_s1;
	logic          sin_neg_s1;
	logic          cos_neg_s1;

	// fold index into the first quadrant, cosine is a quarter turn ahead
	always_comb begin
		idx   = angle[15 -: B];
		q_sin = idx[B-1 -: 2];
		q_cos = q_sin + 2'd1;
		r_ext = {1'b0, idx[B-3:0]};
		j_sin = q_sin[0] ? JW'(QTR) - r_ext : r_ext;
		j_cos = q_cos[0] ? JW'(QTR) - r_ext : r_ext;
	end

	// stage a: folded addresses and signs
	always_ff @(posedge clk) begin
		if (en_a) begin
			j_sin_s1   <= j_sin;
			j_cos_s1   <= j_cos;
			sin_neg_s1 <= q_sin[1];
			cos_neg_s1 <= q_cos[1];
		end
	end

	// stage b: rom read
	always_ff @(posedge clk) begin
		if (en_b) begin
			sin_mag <= SIN_ROM[j_sin_s1];
			cos_mag <= SIN_ROM[j_cos_s1];
			sin_neg <= sin_neg_s1;
			cos_neg <= cos_neg_s1;
		end
	end

endmodule

`default_nettype wire

### sv/vrot_step.sv
// ----------------------------------------------------------------------------
// vrot_step
// One axis rotation: four products in the first stage, then combine,
// truncate toward zero and saturate to 16 bits in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module vrot_step #(
	parameter int COEF_FRAC_BITS = vrot_pkg::COEF_FRAC_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    en_a,
	input  wire logic                    en_b,
	input  wire vrot_pkg::vec_t          vin,
	input  wire vrot_pkg::axis_t         axis,
	input  wire logic [COEF_FRAC_BITS:0] sin_mag,
	input  wire logic                    sin_neg,
	input  wire logic [COEF_FRAC_BITS:0] cos_mag,
	input  wire logic                    cos_neg,
	output vrot_pkg::vec_t               vout
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = F + 2;
	localparam int PW = 16 + CW;
	localparam int SW = PW + 1;
	localparam int QW = SW - F;

	localparam logic signed [SW-1:0] BIAS    = SW'((64'd1 << F) - 64'd1);
	localparam logic signed [QW-1:0] SAT_MAX = QW'(32767);
	localparam logic signed [QW-1:0] SAT_MIN = -QW'(32768);

	// scale down by 2^F toward zero, then clamp; bit 16 flags a clamp
	function automatic logic [16:0] scale_sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] biased;
		logic signed [QW-1:0] q;
		biased = v + (v[SW-1] ? BIAS : '0);
		q      = biased[SW-1:F];
		if (q > SAT_MAX)
			return {1'b1, 16'h7FFF};
		else if (q < SAT_MIN)
			return {1'b1, 16'h8000};
		else
			return {1'b0, q[15:0]};
	endfunction

	logic signed [15:0] a_v;
	logic signed [15:0] b_v;
	logic signed [CW-1:0] s_ext;
	logic signed [CW-1:0] c_ext;
	logic signed [CW-1:0] s_val;
	logic signed [CW-1:0] c_val;

	logic signed [PW-1:0] ac_s1;
	logic signed [PW-1:0] bs_s1;
	logic signed [PW-1:0] as_s1;
	logic signed [PW-1:0] bc_s1;
	vrot_pkg::vec_t       vec_s1;
	vrot_pkg::axis_t      axis_s1;

	logic signed [SW-1:0] na;
	logic signed [SW-1:0] nb;
	logic [16:0]          ra;
	logic [16:0]          rb;
	vrot_pkg::vec_t       vnext;

	// pick the pair and sign the coefficients
	always_comb begin
		unique case (axis)
			vrot_pkg::AXIS_X: begin
				a_v = vin.y;
				b_v = vin.z;
			end
			vrot_pkg::AXIS_Y: begin
				a_v = vin.z;
				b_v = vin.x;
			end
			vrot_pkg::AXIS_Z: begin
				a_v = vin.x;
				b_v = vin.y;
			end
			default: begin
				a_v = vin.x;
				b_v = vin.y;
			end
		endcase
		s_ext = signed'({1'b0, sin_mag});
		c_ext = signed'({1'b0, cos_mag});
		s_val = sin_neg ? -s_ext : s_ext;
		c_val = cos_neg ? -c_ext : c_ext;
	end

	// stage a: products
	always_ff @(posedge clk) begin
		if (en_a) begin
			ac_s1   <= PW'(a_v) * PW'(c_val);
			bs_s1   <= PW'(b_v) * PW'(s_val);
			as_s1   <= PW'(a_v) * PW'(s_val);
			bc_s1   <= PW'(b_v) * PW'(c_val);
			vec_s1  <= vin;
			axis_s1 <= axis;
		end
	end

	// combine, scale, saturate and put the pair back in place
	always_comb begin
		na    = SW'(ac_s1) - SW'(bs_s1);
		nb    = SW'(as_s1) + SW'(bc_s1);
		ra    = scale_sat(na);
		rb    = scale_sat(nb);
		vnext = vec_s1;
		vnext.clip = vec_s1.clip | ra[16] | rb[16];
		unique case (axis_s1)
			vrot_pkg::AXIS_X: begin
				vnext.y = ra[15:0];
				vnext.z = rb[15:0];
			end
			vrot_pkg::AXIS_Y: begin
				vnext.z = ra[15:0];
				vnext.x = rb[15:0];
			end
			vrot_pkg::AXIS_Z: begin
				vnext.x = ra[15:0];
				vnext.y = rb[15:0];
			end
			default: begin
				vnext.x = ra[15:0];
				vnext.y = rb[15:0];
			end
		endcase
	end

	// stage b: rotated vector
	always_ff @(posedge clk) begin
		if (en_b)
			vout <= vnext;
	end

endmodule

`default_nettype wire
